FILE: hdl/q8bdp_pkg.sv
// Shared types, constants and half-float helpers for the Q8_0 block dot product.
// Used by every module under hdl/; depends on nothing.
`default_nettype none
package q8bdp_pkg;

  localparam int LANES   = 8;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = 16;   // signed byte times signed byte
  localparam int TREE_W  = 19;   // sum of LANES products
  localparam int HALF_W  = 16;
  localparam int MANT_W  = 11;   // half significand with hidden bit
  localparam int EXPB_W  = 5;
  localparam int SMAG_W  = 22;   // product of two significands
  localparam int SH_W    = 7;    // signed binary point shift
  localparam int ACC_W   = 64;

  localparam logic [EXPB_W-1:0] EXP_SPECIAL = 5'h1F;
  localparam logic [EXPB_W-1:0] EXP_SUBNORM = 5'h00;
  localparam logic [EXPB_W-1:0] EXP_MAXFIN  = 5'd30;
  localparam logic [EXPB_W-1:0] EXP_MINNORM = 5'd1;
  // shift = ew + eq - 50 + 32, both exponents still biased by 25
  localparam logic [SH_W-1:0]   SHIFT_BIAS  = 7'd18;

  localparam logic [ACC_W-1:0] ACC_BIAS = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  // Control carried with one chunk into the merge stage
  typedef struct packed {
    logic              first;
    logic              last;
    logic              row_end;
    logic [HALF_W-1:0] w_scale;
    logic [HALF_W-1:0] a_scale;
  } chunk_ctl_t;

  // Control carried with one closed block into the fold pipeline
  typedef struct packed {
    logic                   row_end;
    logic                   scale_neg;
    logic [SMAG_W-1:0]      scale_mag;
    logic signed [SH_W-1:0] shift;
  } blk_ctl_t;

  // Integer significand of a half; infinities and NaNs read as 65504
  function automatic logic [MANT_W-1:0] half_mant(input logic [HALF_W-1:0] h);
    logic [EXPB_W-1:0] e;
    e = h[14:10];
    if (e == EXP_SPECIAL) begin
      half_mant = {MANT_W{1'b1}};
    end else if (e == EXP_SUBNORM) begin
      half_mant = {1'b0, h[9:0]};
    end else begin
      half_mant = {1'b1, h[9:0]};
    end
  endfunction

  // Biased exponent of a half as used by the significand above
  function automatic logic [EXPB_W-1:0] half_expb(input logic [HALF_W-1:0] h);
    logic [EXPB_W-1:0] e;
    e = h[14:10];
    if (e == EXP_SPECIAL) begin
      half_expb = EXP_MAXFIN;
    end else if (e == EXP_SUBNORM) begin
      half_expb = EXP_MINNORM;
    end else begin
      half_expb = e;
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/q8bdp_lane.sv
// One multiply lane: signed byte product, registered.
// Depends on q8bdp_pkg.
`default_nettype none
module q8bdp_lane
  import q8bdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [BYTE_W-1:0] w_byte,
  input  wire logic [BYTE_W-1:0] a_byte,
  output logic      [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = $signed(w_byte) * $signed(a_byte);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/q8bdp_merge.sv
// Merge stage: sums the lane products, keeps the block partial sum and the
// block scale pair, and hands each closed block to the fold pipeline. Uses q8bdp_pkg.
`default_nettype none
module q8bdp_merge
  import q8bdp_pkg::*;
#(
  parameter int PSUM_W = 21
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    chk_vld,
  input  wire chunk_ctl_t              chk_ctl,
  input  wire logic [LANES*PROD_W-1:0] prod_flat,
  output logic                         blk_vld_r,
  output logic signed [PSUM_W-1:0]     blk_sum_r,
  output blk_ctl_t                     blk_ctl_r
);

  logic signed [TREE_W-1:0] tree_sum;
  logic signed [PSUM_W-1:0] bpart_r;
  logic signed [PSUM_W-1:0] total;
  logic [SMAG_W-1:0]        fresh_mag;
  blk_ctl_t                 fresh_ctl;
  blk_ctl_t                 scale_r;
  blk_ctl_t                 cur_ctl;

  // adder tree over the lanes
  always_comb begin
    tree_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      tree_sum = tree_sum + TREE_W'($signed(prod_flat[i*PROD_W +: PROD_W]));
    end
  end

  // partial is zero at a block's first chunk
  assign total = bpart_r + PSUM_W'(tree_sum);

  // scale pair of a block's first chunk, decoded
  assign fresh_mag = SMAG_W'(half_mant(chk_ctl.w_scale)) * SMAG_W'(half_mant(chk_ctl.a_scale));
  always_comb begin
    fresh_ctl           = '0;
    fresh_ctl.scale_neg = chk_ctl.w_scale[HALF_W-1] ^ chk_ctl.a_scale[HALF_W-1];
    fresh_ctl.scale_mag = fresh_mag;
    fresh_ctl.shift     = $signed(SH_W'(half_expb(chk_ctl.w_scale))
                        + SH_W'(half_expb(chk_ctl.a_scale)) - SHIFT_BIAS);
    cur_ctl             = chk_ctl.first ? fresh_ctl : scale_r;
    cur_ctl.row_end     = chk_ctl.row_end;
  end

  // block partial sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpart_r <= '0;
    end else if (adv && chk_vld) begin
      bpart_r <= chk_ctl.last ? '0 : total;
    end
  end

  // latched scale pair
  always_ff @(posedge clk) begin
    if (adv && chk_vld && chk_ctl.first) begin
      scale_r <= fresh_ctl;
    end
  end

  // closed block out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_vld_r <= 1'b0;
    end else if (adv) begin
      blk_vld_r <= chk_vld && chk_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk_sum_r <= total;
      blk_ctl_r <= cur_ctl;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/q8bdp_fold.sv
// Fold pipeline: scales a block sum, aligns it to Q31.32, adds it to the
// saturating row accumulator and holds the row result. Uses q8bdp_pkg.
`default_nettype none
module q8bdp_fold
  import q8bdp_pkg::*;
#(
  parameter int PSUM_W = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  output logic                     hold,
  input  wire logic                blk_vld,
  input  wire logic signed [PSUM_W-1:0] blk_sum,
  input  wire blk_ctl_t            blk_ctl,
  output logic                     out_vld_r,
  input  wire logic                out_rdy,
  output logic [ACC_W-1:0]         out_data_r,
  output logic                     out_flag_r
);

  localparam int MAG_W  = PSUM_W + SMAG_W;
  localparam int WIDE_W = MAG_W + (2 ** (SH_W - 1)) - 1;

  // stage 1: magnitude times scale
  logic [PSUM_W-1:0]      s_abs;
  logic                   m_vld_r;
  logic [MAG_W-1:0]       m_mag_r;
  logic                   m_neg_r;
  logic                   m_end_r;
  logic signed [SH_W-1:0] m_sh_r;

  assign s_abs = blk_sum[PSUM_W-1] ? PSUM_W'(-blk_sum) : PSUM_W'(blk_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= blk_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_mag_r <= MAG_W'(s_abs) * MAG_W'(blk_ctl.scale_mag);
      m_neg_r <= blk_ctl.scale_neg ^ blk_sum[PSUM_W-1];
      m_end_r <= blk_ctl.row_end;
      m_sh_r  <= blk_ctl.shift;
    end
  end

  // stage 2: align to 32 fraction bits, flag terms that do not fit
  logic [WIDE_W-1:0]      wide;
  logic [SH_W-2:0]        sh_left;
  logic [SH_W-1:0]        sh_neg;
  logic [ACC_W-1:0]       a_mag;
  logic                   a_ovf;
  logic                   t_vld_r;
  logic [ACC_W-1:0]       t_mag_r;
  logic                   t_ovf_r;
  logic                   t_neg_r;
  logic                   t_end_r;

  assign sh_left = m_sh_r[SH_W-2:0];
  assign sh_neg  = SH_W'(-m_sh_r);
  assign wide    = WIDE_W'(m_mag_r) << sh_left;

  always_comb begin
    if (!m_sh_r[SH_W-1]) begin
      a_ovf = |wide[WIDE_W-1:ACC_W];
      a_mag = wide[ACC_W-1:0];
    end else begin
      a_ovf = 1'b0;
      a_mag = ACC_W'(m_mag_r >> sh_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (adv) begin
      t_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_mag_r <= a_mag;
      t_ovf_r <= a_ovf;
      t_neg_r <= m_neg_r;
      t_end_r <= m_end_r;
    end
  end

  // stage 3: saturating accumulate in offset binary
  logic [ACC_W-1:0] acc_r;
  logic             flag_r;
  logic [ACC_W-1:0] ubias;
  logic [ACC_W:0]   usum;
  logic [ACC_W-1:0] acc_nxt;
  logic             flag_nxt;

  assign ubias = acc_r ^ ACC_BIAS;
  assign usum  = {1'b0, ubias} + {1'b0, t_mag_r};

  always_comb begin
    acc_nxt  = acc_r;
    flag_nxt = flag_r;
    if (t_ovf_r) begin
      acc_nxt  = t_neg_r ? ACC_MIN : ACC_MAX;
      flag_nxt = 1'b1;
    end else if (t_mag_r != '0) begin
      if (!t_neg_r) begin
        if (usum[ACC_W]) begin
          acc_nxt  = ACC_MAX;
          flag_nxt = 1'b1;
        end else begin
          acc_nxt = usum[ACC_W-1:0] ^ ACC_BIAS;
        end
      end else begin
        if (t_mag_r > ubias) begin
          acc_nxt  = ACC_MIN;
          flag_nxt = 1'b1;
        end else begin
          acc_nxt = (ubias - t_mag_r) ^ ACC_BIAS;
        end
      end
    end
  end

  // a row result cannot leave while the previous one still waits
  assign hold = t_vld_r && t_end_r && out_vld_r && !out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      flag_r <= 1'b0;
    end else if (adv && t_vld_r) begin
      acc_r  <= t_end_r ? '0 : acc_nxt;
      flag_r <= t_end_r ? 1'b0 : flag_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && t_vld_r && t_end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && t_vld_r && t_end_r) begin
      out_data_r <= acc_nxt;
      out_flag_r <= flag_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/q8_block_quantized_dot_product.sv
// Top level of the Q8_0 block dot product: input stage, eight multiply lanes,
// merge stage and fold pipeline. Depends on q8bdp_pkg, q8bdp_lane, q8bdp_merge, q8bdp_fold.
//
// Takes one beat per clock while the pipeline is not stalled: eight weight bytes
// and eight activation bytes, with the two half scales read on the first beat of
// each block of BLOCK_VALUES values. The eight lane multipliers register their
// products and the adder tree sum is registered in the merge stage; a closed block
// then passes a registered scale multiply, a registered alignment shift and the
// saturating 64-bit accumulate. The row result (Q31.32 value in out_tdata,
// saturation flag in out_tuser) is held in the output register. The whole
// pipeline stalls only while a row result waits in the output register and the
// next row-end beat reaches the accumulator.
`default_nettype none
module q8_block_quantized_dot_product
  import q8bdp_pkg::*;
#(
  parameter int BLOCK_VALUES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [63:0] weight_bytes, [127:64] act_bytes, [143:128] weight_scale, [159:144] act_scale
  input  wire logic [159:0] in_tdata,
  input  wire logic         in_tlast,    // row_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,   // [63:0] dot_value
  output logic [0:0]        out_tuser    // [0] overflowed
);

  localparam int CHUNKS = (BLOCK_VALUES + LANES - 1) / LANES;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PSUM_W = $clog2(BLOCK_VALUES) + 16;

  logic                    adv;
  logic                    hold;
  logic                    in_fire;
  logic [CNT_W-1:0]        chunk_cnt_r;
  logic                    last_chunk;
  logic                    chk_vld_r;
  chunk_ctl_t              chk_ctl_r;
  logic [LANES*PROD_W-1:0] prod_flat;
  logic                    blk_vld;
  logic signed [PSUM_W-1:0] blk_sum;
  blk_ctl_t                blk_ctl;
  logic [ACC_W-1:0]        out_data;
  logic                    out_flag;

  assign adv       = !hold;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && in_tready;

  // chunk position within the block
  assign last_chunk = (chunk_cnt_r == CNT_W'(CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_cnt_r <= '0;
    end else if (in_fire) begin
      chunk_cnt_r <= (in_tlast || last_chunk) ? '0 : chunk_cnt_r + 1'b1;
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else if (adv) begin
      chk_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chk_ctl_r.first   <= (chunk_cnt_r == '0);
      chk_ctl_r.last    <= in_tlast || last_chunk;
      chk_ctl_r.row_end <= in_tlast;
      chk_ctl_r.w_scale <= in_tdata[143:128];
      chk_ctl_r.a_scale <= in_tdata[159:144];
    end
  end

  // multiply lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8bdp_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .w_byte (in_tdata[g*BYTE_W +: BYTE_W]),
      .a_byte (in_tdata[LANES*BYTE_W + g*BYTE_W +: BYTE_W]),
      .prod_r (prod_flat[g*PROD_W +: PROD_W])
    );
  end

  q8bdp_merge #(
    .PSUM_W (PSUM_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .chk_vld   (chk_vld_r),
    .chk_ctl   (chk_ctl_r),
    .prod_flat (prod_flat),
    .blk_vld_r (blk_vld),
    .blk_sum_r (blk_sum),
    .blk_ctl_r (blk_ctl)
  );

  q8bdp_fold #(
    .PSUM_W (PSUM_W)
  ) u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .hold       (hold),
    .blk_vld    (blk_vld),
    .blk_sum    (blk_sum),
    .blk_ctl    (blk_ctl),
    .out_vld_r  (out_tvalid),
    .out_rdy    (out_tready),
    .out_data_r (out_data),
    .out_flag_r (out_flag)
  );

  assign out_tdata = out_data;
  assign out_tuser = out_flag;

endmodule
`default_nettype wire

FILE: verif/q8_block_quantized_dot_product_test.sv
// Self-checking testbench for q8_block_quantized_dot_product: random-gap stream driver,
// stalling result sink and a bit-exact Q31.32 row predictor. Needs only the RTL under hdl/.
`default_nettype none
module q8_block_quantized_dot_product_test;

  localparam int BLOCK_CHUNKS  = 4;      // 32 values per block, 8 lanes per beat
  localparam int RANDOM_BEATS  = 500;
  localparam int HOLD_CYCLES   = 400;    // long sink hold-off, fills the pipeline
  localparam int IDLE_LIMIT    = 4000;   // cycles with no beat on either side
  localparam int DRAIN_CYCLES  = 32;
  localparam logic [63:0] Q_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_BIAS = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL7F  = {8{8'h7F}};
  localparam logic [63:0] ALL80  = {8{8'h80}};

  typedef struct {
    logic [63:0] wbytes;
    logic [63:0] abytes;
    logic [15:0] wscale;
    logic [15:0] ascale;
    logic        row_end;
  } chunk_beat_t;

  typedef struct {
    logic [63:0] dot;
    logic        ovf;
  } row_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;

  q8_block_quantized_dot_product uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chunk_beat_t pending_beats[$];
  row_result_t expected_rows[$];
  int          mismatches = 0;
  int          rows_checked = 0;

  // Predictor state: mirrors the block's chunk, block and row registers
  logic [1:0]  blk_chunk = '0;
  int          blk_sum = 0;
  logic [31:0] blk_scales = '0;
  logic [63:0] row_acc = '0;
  logic        row_sat = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Half scale as sign, integer significand and power-of-two exponent
  task automatic split_half(input logic [15:0] h, output logic neg,
                            output logic [63:0] mant, output int expo);
    neg = h[15];
    if (h[14:10] == 5'h1F) begin
      mant = 64'd2047;
      expo = 5;
    end else if (h[14:10] == 5'h00) begin
      mant = {54'd0, h[9:0]};
      expo = -24;
    end else begin
      mant = {53'd0, 1'b1, h[9:0]};
      expo = int'(h[14:10]) - 25;
    end
  endtask

  task automatic clamp_row(input logic neg);
    row_acc = neg ? Q_MIN : Q_MAX;
    row_sat = 1'b1;
  endtask

  // Scale the closed block's integer sum and add it into the row, saturating
  task automatic fold_block_into_row();
    logic        wn, an, neg;
    logic [63:0] wm, am, mag, u;
    int          we, ae, sh;
    split_half(blk_scales[31:16], wn, wm, we);
    split_half(blk_scales[15:0], an, am, ae);
    neg = (wn ^ an) != (blk_sum < 0);
    mag = 64'(blk_sum < 0 ? -blk_sum : blk_sum) * wm * am;
    sh = we + ae + 32;
    if (sh > 0 && mag > ({64{1'b1}} >> sh)) begin
      clamp_row(neg);
    end else begin
      if (sh >= 0) begin
        mag = mag << sh;
      end else begin
        mag = mag >> (-sh);
      end
      if (mag != 64'd0) begin
        u = row_acc ^ Q_BIAS;
        if (!neg) begin
          if (mag > ~u) begin
            clamp_row(1'b0);
          end else begin
            row_acc = (u + mag) ^ Q_BIAS;
          end
        end else begin
          if (mag > u) begin
            clamp_row(1'b1);
          end else begin
            row_acc = (u - mag) ^ Q_BIAS;
          end
        end
      end
    end
  endtask

  // Advance the predictor by one accepted input beat
  task automatic absorb_chunk(input chunk_beat_t c);
    logic signed [7:0] wb, ab;
    int                sum;
    row_result_t       r;
    sum = 0;
    if (blk_chunk == 2'd0) begin
      blk_scales = {c.wscale, c.ascale};
    end
    for (int i = 0; i < 8; i++) begin
      wb = c.wbytes[8*i +: 8];
      ab = c.abytes[8*i +: 8];
      sum += int'(wb) * int'(ab);
    end
    blk_sum += sum;
    if (c.row_end || blk_chunk == 2'(BLOCK_CHUNKS - 1)) begin
      fold_block_into_row();
      blk_sum = 0;
      blk_chunk = '0;
    end else begin
      blk_chunk++;
    end
    if (c.row_end) begin
      r.dot = row_acc;
      r.ovf = row_sat;
      expected_rows.push_back(r);
      row_acc = '0;
      row_sat = 1'b0;
    end
  endtask

  // Stimulus builders
  task automatic add_chunk(input logic [63:0] w, input logic [63:0] a,
                           input logic [15:0] ws, input logic [15:0] as, input logic last);
    chunk_beat_t c;
    c.wbytes = w;
    c.abytes = a;
    c.wscale = ws;
    c.ascale = as;
    c.row_end = last;
    pending_beats.push_back(c);
  endtask

  // Later chunks carry inverted scales, which the block must ignore
  task automatic add_block(input logic [63:0] w, input logic [63:0] a, input logic [15:0] ws,
                           input logic [15:0] as, input int nchunks, input logic ends_row);
    for (int i = 0; i < nchunks; i++) begin
      add_chunk(w, a, (i == 0) ? ws : ~ws, (i == 0) ? as : ~as,
                ends_row && (i == nchunks - 1));
    end
  endtask

  function automatic logic [63:0] rand_lanes();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = ALL7F;
      1: v = ALL80;
      2: begin
        for (int i = 0; i < 8; i++) begin
          v[8*i +: 8] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
        end
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 9))
      6: ;                                         // raw pattern
      7: h[14:10] = 5'h1F;                         // infinity or NaN
      8: h[14:10] = 5'h00;                         // subnormal or zero
      9: h[14:10] = 5'($urandom_range(19, 24));    // big, saturates often
      default: h[14:10] = 5'($urandom_range(8, 18));
    endcase
    return h;
  endfunction

  // Mostly full blocks, with a short final block now and then
  task automatic add_random_row();
    int nblk, nch;
    nblk = $urandom_range(1, 3);
    for (int b = 0; b < nblk; b++) begin
      nch = (b == nblk - 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : BLOCK_CHUNKS;
      for (int c = 0; c < nch; c++) begin
        add_chunk(rand_lanes(), rand_lanes(), rand_half(), rand_half(),
                  b == nblk - 1 && c == nch - 1);
      end
    end
  endtask

  // Driver: bursts of beats separated by random gaps, changes on the falling edge
  chunk_beat_t cur_beat;
  logic        in_taken = 1'b0;
  logic        next_valid;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_beats.size() != 0) begin
        cur_beat = pending_beats.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_tvalid <= next_valid;
      if (next_valid) begin
        in_tdata <= {cur_beat.ascale, cur_beat.wscale, cur_beat.abytes, cur_beat.wbytes};
        in_tlast <= cur_beat.row_end;
      end
    end
  end

  // Sink: ready pattern of its own, plus one long hold-off
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   rx_mode = 0;
  int   mode_left = 0;
  logic rx_ready;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rx_ready = 1'b0;
    end else if (!hold_done && rows_checked >= 12) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rx_ready = 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = ($urandom_range(0, 3) != 0);
        default: rx_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_tready <= rx_ready;
  end

  // Monitor: predict on input beats, check result beats
  row_result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        absorb_chunk(cur_beat);
      end
      if (out_tvalid && out_tready) begin
        rows_checked++;
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row result", out_tdata, 64'd0);
        end else begin
          want = expected_rows.pop_front();
          if (out_tdata !== want.dot) begin
            report_mismatch("dot_value", out_tdata, want.dot);
          end
          if (out_tuser[0] !== want.ovf) begin
            report_mismatch("overflowed", {63'd0, out_tuser[0]}, {63'd0, want.ovf});
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted anywhere
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    // Zero and negative zero scales
    add_chunk({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 16'h8000, 1'b1);
    // Largest positive bytes, row ends early on the second chunk
    add_block(ALL7F, ALL7F, 16'h3C00, 16'h3C00, 2, 1'b1);
    // Most negative bytes, negative scale, full block
    add_block(ALL80, ALL80, 16'h3C00, 16'hBC00, 4, 1'b1);
    // Infinity and negative NaN scales read as the largest finite half
    add_chunk(ALL80, ALL7F, 16'h7C00, 16'hFE00, 1'b1);
    // Subnormal scales
    add_chunk(ALL7F, ALL80, 16'h0001, 16'h83FF, 1'b1);
    // Block term too large for the accumulator
    add_block(ALL7F, ALL7F, 16'h7C00, 16'h7BFF, 4, 1'b1);
    // Two blocks that each fit but overflow together
    add_block(ALL7F, ALL7F, 16'h5400, 16'h5400, 4, 1'b0);
    add_block(ALL7F, ALL7F, 16'h5400, 16'h5400, 4, 1'b1);
    // Negative overflow, closed by an early row end
    add_block(ALL80, ALL7F, 16'h5400, 16'h5400, 4, 1'b0);
    add_block(ALL80, ALL7F, 16'h5400, 16'h5400, 1, 1'b1);
    begin : fill_random
      int target;
      target = pending_beats.size() + RANDOM_BEATS;
      while (pending_beats.size() < target) begin
        add_random_row();
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_rows.size() != 0) begin
      want = expected_rows.pop_front();
      report_mismatch("missing row result", 64'd0, want.dot);
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hdl/q8bdp_pkg.sv
hdl/q8bdp_lane.sv
hdl/q8bdp_merge.sv
hdl/q8bdp_fold.sv
hdl/q8_block_quantized_dot_product.sv
verif/q8_block_quantized_dot_product_test.sv
